### design/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared sizes, request and result codes, item types and slot arithmetic
// for the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

    // Wheel geometry.
    localparam int POOL_ENTRIES = 64;
    localparam int NEAR_BITS    = 8;
    localparam int LEVEL_BITS   = 6;
    localparam int UPPER_LEVELS = 4;

    localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
    localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
    localparam int NUM_SLOTS   = NEAR_SLOTS + UPPER_LEVELS * LEVEL_SLOTS;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int ENTRY_W     = $clog2(POOL_ENTRIES);
    localparam int PTR_W       = $clog2(POOL_ENTRIES + 1);
    localparam int DATA_W      = 32 + 31;

    // The list terminator is one past the last pool entry.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    // Request codes.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    // Result codes.
    localparam logic [2:0] KIND_EXPIRED   = 3'd0;
    localparam logic [2:0] KIND_NONE      = 3'd1;
    localparam logic [2:0] KIND_ADDED     = 3'd2;
    localparam logic [2:0] KIND_IMMEDIATE = 3'd3;
    localparam logic [2:0] KIND_CANCELLED = 3'd4;
    localparam logic [2:0] KIND_REJECTED  = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  timer_id;
        logic [30:0] interval_ticks;
        logic        recurring;
    } req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] expired_id;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } casc_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_CANCEL,
        ST_BAD,
        ST_FIRE_RD,
        ST_DETACH,
        ST_WALK,
        ST_ITEM,
        ST_EMIT,
        ST_ADVANCE,
        ST_PLACE,
        ST_APPEND,
        ST_LINK,
        ST_FIN
    } state_t;

    // Slot that an entry with the given expiry belongs in at the given tick.
    function automatic logic [SLOT_W-1:0] place_slot(input logic [31:0] exp,
                                                     input logic [31:0] tick);
        logic [63:0]       rem64;
        logic [63:0]       digit;
        logic              found;
        logic [SLOT_W-1:0] s;
        rem64 = {32'd0, exp - tick};
        s     = SLOT_W'(exp[NEAR_BITS-1:0]);
        found = rem64 < 64'(NEAR_SLOTS);
        for (int i = 0; i < UPPER_LEVELS; i++) begin
            if (!found && (i == UPPER_LEVELS - 1 ||
                           rem64 < (64'd1 << (NEAR_BITS + (i + 1) * LEVEL_BITS)))) begin
                digit = ({32'd0, exp} >> (NEAR_BITS + i * LEVEL_BITS)) & 64'(LEVEL_SLOTS - 1);
                s     = SLOT_W'(64'(NEAR_SLOTS + i * LEVEL_SLOTS) + digit);
                found = 1'b1;
            end
        end
        return s;
    endfunction

    // Upper slot to cascade after the tick count has moved to ct, if any.
    function automatic casc_t casc_slot(input logic [31:0] ct);
        casc_t       r;
        logic        go;
        logic [63:0] ct64;
        logic [63:0] low;
        logic [63:0] digit;
        ct64   = {32'd0, ct};
        r.hit  = 1'b0;
        r.slot = '0;
        go     = 1'b1;
        if (ct == 32'd0) begin
            r.hit  = 1'b1;
            r.slot = SLOT_W'(NEAR_SLOTS + (UPPER_LEVELS - 1) * LEVEL_SLOTS);
            go     = 1'b0;
        end
        for (int i = 0; i < UPPER_LEVELS; i++) begin
            if (go) begin
                low   = ct64 & ((64'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 64'd1);
                digit = (ct64 >> (NEAR_BITS + i * LEVEL_BITS)) & 64'(LEVEL_SLOTS - 1);
                if (low != 64'd0) begin
                    go = 1'b0;
                end else if (digit != 64'd0) begin
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(64'(NEAR_SLOTS + i * LEVEL_SLOTS) + digit);
                    go     = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

### design/hierarchical_timer_wheel.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Hierarchical timing wheel with a near wheel and upper wheels over a pool
// of timer entries; slot lists and entries live in block RAM.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel (valid/ready) as one item: a tick, an
// add or a cancel. Results leave on the m_ channel, one item per expired
// timer or per add/cancel answer, with last set on the final item of a
// request. A tick with nothing expired gives one item of kind "none".
// One request is worked at a time; s_ready is high only between requests.
// A tick fires the near slot of the current tick, advances the tick count,
// cascades the upper slot whose digit rolled over, if any, and then fires
// the near slot of the new tick. Every list step goes through a registered
// read of the slot and entry memories. Results pass through an output
// register, so the next request is taken while the last item still waits
// on m_ready; a stall on m_ready holds the walk only when a new result
// must be pushed.
// After reset a clearing pass writes every slot head empty, one slot per
// cycle (NUM_SLOTS = 512 slots), with s_ready low; the tick count and all
// entry flags clear at once.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel
    import htw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [31:0]             tick_reg, tick_next;
    logic [POOL_ENTRIES-1:0] linked_reg, linked_next;
    logic [POOL_ENTRIES-1:0] recur_reg, recur_next;
    logic [POOL_ENTRIES-1:0] cancel_reg, cancel_next;
    req_t                    req_reg, req_next;
    logic                    phase_reg, phase_next;
    logic                    casc_reg, casc_next;
    logic                    is_add_reg, is_add_next;
    logic [PTR_W-1:0]        cur_e_reg, cur_e_next;
    logic [PTR_W-1:0]        nx_reg, nx_next;
    logic [31:0]             exp_reg, exp_next;
    logic [30:0]             per_reg, per_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic                    held_v_reg, held_v_next;
    logic [2:0]              held_kind_reg, held_kind_next;
    logic [5:0]              held_id_reg, held_id_next;
    logic                    out_v_reg, out_v_next;
    rsp_t                    out_reg, out_next;

    // Memory ports.
    logic                   slot_we, slot_re;
    logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
    logic [2*PTR_W-1:0]     slot_wdata, slot_rdata;
    logic                   next_we, next_re;
    logic [ENTRY_W-1:0]     next_waddr, next_raddr;
    logic [PTR_W-1:0]       next_wdata, next_rdata;
    logic                   data_we, data_re;
    logic [ENTRY_W-1:0]     data_waddr, data_raddr;
    logic [DATA_W-1:0]      data_wdata, data_rdata;

    logic [PTR_W-1:0]   rd_head, rd_tail;
    logic [ENTRY_W-1:0] e_idx;
    logic [ENTRY_W-1:0] req_idx;
    logic               req_id_ok;
    logic               out_ok;
    logic               emit_go;
    logic [31:0]        rearm_exp;
    casc_t              casc;

    assign rd_head   = slot_rdata[2*PTR_W-1:PTR_W];
    assign rd_tail   = slot_rdata[PTR_W-1:0];
    assign e_idx     = cur_e_reg[ENTRY_W-1:0];
    assign req_idx   = req_reg.timer_id[ENTRY_W-1:0];
    assign req_id_ok = 32'(req_reg.timer_id) < POOL_ENTRIES;
    assign out_ok    = !out_v_reg || m_ready;
    assign emit_go   = !held_v_reg || out_ok;
    assign rearm_exp = tick_reg + {1'b0, per_reg};
    assign casc      = casc_slot(tick_reg + 32'd1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .aclk (aclk), .we (slot_we), .waddr (slot_waddr), .wdata (slot_wdata),
        .re (slot_re), .raddr (slot_raddr), .rdata (slot_rdata)
    );

    htw_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .aclk (aclk), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
        .re (next_re), .raddr (next_raddr), .rdata (next_rdata)
    );

    htw_ram #(.WIDTH(DATA_W), .DEPTH(POOL_ENTRIES)) u_data_ram (
        .aclk (aclk), .we (data_we), .waddr (data_waddr), .wdata (data_wdata),
        .re (data_re), .raddr (data_raddr), .rdata (data_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SLOT_W'(NUM_SLOTS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.func)
                        FUNC_TICK:   state_next = ST_FIRE_RD;
                        FUNC_ADD:    state_next = ST_ADD;
                        FUNC_CANCEL: state_next = ST_CANCEL;
                        default:     state_next = ST_BAD;
                    endcase
                end
            end
            ST_ADD: begin
                if (!req_id_ok || linked_reg[req_idx] || req_reg.interval_ticks == 31'd0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_CANCEL, ST_BAD: state_next = ST_FIN;
            ST_FIRE_RD:        state_next = ST_DETACH;
            ST_DETACH:         state_next = ST_WALK;
            ST_WALK: begin
                if (cur_e_reg != NIL)  state_next = ST_ITEM;
                else if (casc_reg)     state_next = ST_FIRE_RD;
                else if (!phase_reg)   state_next = ST_ADVANCE;
                else                   state_next = ST_FIN;
            end
            ST_ITEM: begin
                if (casc_reg)               state_next = ST_PLACE;
                else if (cancel_reg[e_idx]) state_next = ST_WALK;
                else                        state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go) state_next = recur_reg[e_idx] ? ST_PLACE : ST_WALK;
            end
            ST_ADVANCE: state_next = casc.hit ? ST_DETACH : ST_FIRE_RD;
            ST_PLACE:   state_next = ST_APPEND;
            ST_APPEND: begin
                if (rd_head != NIL) state_next = ST_LINK;
                else                state_next = is_add_reg ? ST_FIN : ST_WALK;
            end
            ST_LINK: state_next = is_add_reg ? ST_FIN : ST_WALK;
            ST_FIN: begin
                if (out_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, flag updates and memory controls per state.
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        tick_next      = tick_reg;
        linked_next    = linked_reg;
        recur_next     = recur_reg;
        cancel_next    = cancel_reg;
        req_next       = req_reg;
        phase_next     = phase_reg;
        casc_next      = casc_reg;
        is_add_next    = is_add_reg;
        cur_e_next     = cur_e_reg;
        nx_next        = nx_reg;
        exp_next       = exp_reg;
        per_next       = per_reg;
        slot_next      = slot_reg;
        tail_next      = tail_reg;
        held_v_next    = held_v_reg;
        held_kind_next = held_kind_reg;
        held_id_next   = held_id_reg;
        out_v_next     = out_v_reg && !m_ready;
        out_next       = out_reg;

        slot_we    = 1'b0;
        slot_waddr = slot_reg;
        slot_wdata = {NIL, NIL};
        slot_re    = 1'b0;
        slot_raddr = slot_reg;
        next_we    = 1'b0;
        next_waddr = e_idx;
        next_wdata = NIL;
        next_re    = 1'b0;
        next_raddr = e_idx;
        data_we    = 1'b0;
        data_waddr = e_idx;
        data_wdata = {exp_reg, per_reg};
        data_re    = 1'b0;
        data_raddr = e_idx;

        unique case (state_reg)
            ST_CLEAR: begin
                slot_we      = 1'b1;
                slot_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    phase_next  = 1'b0;
                    casc_next   = 1'b0;
                    is_add_next = 1'b0;
                end
            end
            ST_ADD: begin
                held_v_next  = 1'b1;
                held_id_next = req_reg.timer_id;
                if (!req_id_ok || linked_reg[req_idx]) begin
                    held_kind_next = KIND_REJECTED;
                end else if (req_reg.interval_ticks == 31'd0) begin
                    held_kind_next = KIND_IMMEDIATE;
                end else begin
                    held_kind_next       = KIND_ADDED;
                    linked_next[req_idx] = 1'b1;
                    recur_next[req_idx]  = req_reg.recurring;
                    cancel_next[req_idx] = 1'b0;
                    is_add_next          = 1'b1;
                    cur_e_next           = PTR_W'(req_idx);
                    exp_next             = tick_reg + {1'b0, req_reg.interval_ticks};
                    data_we              = 1'b1;
                    data_waddr           = req_idx;
                    data_wdata           = {tick_reg + {1'b0, req_reg.interval_ticks},
                                            req_reg.interval_ticks};
                end
            end
            ST_CANCEL: begin
                held_v_next  = 1'b1;
                held_id_next = req_reg.timer_id;
                if (req_id_ok && linked_reg[req_idx] && !cancel_reg[req_idx]) begin
                    held_kind_next       = KIND_CANCELLED;
                    cancel_next[req_idx] = 1'b1;
                end else begin
                    held_kind_next = KIND_REJECTED;
                end
            end
            ST_BAD: begin
                held_v_next    = 1'b1;
                held_id_next   = req_reg.timer_id;
                held_kind_next = KIND_REJECTED;
            end
            ST_FIRE_RD: begin
                slot_next  = SLOT_W'(tick_reg[NEAR_BITS-1:0]);
                slot_re    = 1'b1;
                slot_raddr = SLOT_W'(tick_reg[NEAR_BITS-1:0]);
            end
            ST_DETACH: begin
                // Detach the whole list before walking it.
                slot_we    = 1'b1;
                slot_wdata = {NIL, rd_tail};
                cur_e_next = rd_head;
            end
            ST_WALK: begin
                if (cur_e_reg != NIL) begin
                    next_re = 1'b1;
                    data_re = 1'b1;
                end else if (casc_reg) begin
                    casc_next  = 1'b0;
                    phase_next = 1'b1;
                end
            end
            ST_ITEM: begin
                nx_next  = next_rdata;
                exp_next = data_rdata[DATA_W-1:31];
                per_next = data_rdata[30:0];
                if (!casc_reg && cancel_reg[e_idx]) begin
                    linked_next[e_idx] = 1'b0;
                    recur_next[e_idx]  = 1'b0;
                    cancel_next[e_idx] = 1'b0;
                    cur_e_next         = next_rdata;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    if (held_v_reg) begin
                        out_v_next = 1'b1;
                        out_next   = '{kind: held_kind_reg, expired_id: held_id_reg,
                                       last: 1'b0};
                    end
                    held_v_next    = 1'b1;
                    held_kind_next = KIND_EXPIRED;
                    held_id_next   = 6'(e_idx);
                    if (recur_reg[e_idx]) begin
                        exp_next   = rearm_exp;
                        data_we    = 1'b1;
                        data_wdata = {rearm_exp, per_reg};
                    end else begin
                        linked_next[e_idx] = 1'b0;
                        recur_next[e_idx]  = 1'b0;
                        cancel_next[e_idx] = 1'b0;
                        cur_e_next         = nx_reg;
                    end
                end
            end
            ST_ADVANCE: begin
                tick_next = tick_reg + 32'd1;
                if (casc.hit) begin
                    casc_next  = 1'b1;
                    slot_next  = casc.slot;
                    slot_re    = 1'b1;
                    slot_raddr = casc.slot;
                end else begin
                    phase_next = 1'b1;
                end
            end
            ST_PLACE: begin
                slot_next  = place_slot(exp_reg, tick_reg);
                slot_re    = 1'b1;
                slot_raddr = place_slot(exp_reg, tick_reg);
            end
            ST_APPEND: begin
                // Entry becomes the new tail of the chosen slot.
                next_we    = 1'b1;
                slot_we    = 1'b1;
                slot_wdata = {(rd_head == NIL) ? cur_e_reg : rd_head, cur_e_reg};
                tail_next  = rd_tail;
                if (rd_head == NIL && !is_add_reg) cur_e_next = nx_reg;
            end
            ST_LINK: begin
                next_we    = 1'b1;
                next_waddr = tail_reg[ENTRY_W-1:0];
                next_wdata = cur_e_reg;
                if (!is_add_reg) cur_e_next = nx_reg;
            end
            ST_FIN: begin
                if (out_ok) begin
                    out_v_next  = 1'b1;
                    held_v_next = 1'b0;
                    if (held_v_reg) begin
                        out_next = '{kind: held_kind_reg, expired_id: held_id_reg,
                                     last: 1'b1};
                    end else begin
                        out_next = '{kind: KIND_NONE, expired_id: 6'd0, last: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            tick_reg    <= '0;
            linked_reg  <= '0;
            recur_reg   <= '0;
            cancel_reg  <= '0;
            held_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            tick_reg    <= tick_next;
            linked_reg  <= linked_next;
            recur_reg   <= recur_next;
            cancel_reg  <= cancel_next;
            held_v_reg  <= held_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        phase_reg     <= phase_next;
        casc_reg      <= casc_next;
        is_add_reg    <= is_add_next;
        cur_e_reg     <= cur_e_next;
        nx_reg        <= nx_next;
        exp_reg       <= exp_next;
        per_reg       <= per_next;
        slot_reg      <= slot_next;
        tail_reg      <= tail_next;
        held_kind_reg <= held_kind_next;
        held_id_reg   <= held_id_next;
        out_reg       <= out_next;
    end

    // Only one request is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    // Only expiry results can be followed by more results of the same request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.kind == KIND_EXPIRED))
        else $error("non-final result of a kind other than expired");

    // A held result never survives into the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !held_v_reg)
        else $error("held result left behind after a request");

    // A cancel mark is only set on a linked entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((cancel_reg & ~linked_reg) == '0))
        else $error("cancel mark on an unlinked entry");

endmodule

### design/htw_ram.sv
// ----------------------------------------------------------------------------
// htw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### bench/hierarchical_timer_wheel_checker.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_checker
// Watches both channels of the timer wheel, keeps its own copy of the wheel
// and pool, works out the results of every accepted request, and compares
// each result item field by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_checker
    import htw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  req_t  s_data,
    input  logic  m_valid,
    input  logic  m_ready,
    input  rsp_t  m_data,
    output int    error_count,
    output int    pending
);

    localparam logic [2:0] FLAG_LINKED = 3'b001;
    localparam logic [2:0] FLAG_RECUR  = 3'b010;
    localparam logic [2:0] FLAG_CANCEL = 3'b100;

    // Shadow of the wheel state.
    logic [31:0] now_tick;
    logic [31:0] due_tick [POOL_ENTRIES];
    logic [30:0] period   [POOL_ENTRIES];
    logic [2:0]  flags    [POOL_ENTRIES];
    int          link     [POOL_ENTRIES];
    int          head     [NUM_SLOTS];
    int          tail     [NUM_SLOTS];

    rsp_t outcome_q[$];
    rsp_t batch_q[$];

    assign pending = outcome_q.size();

    function automatic void clear_wheel();
        now_tick = '0;
        for (int e = 0; e < POOL_ENTRIES; e++) begin
            flags[e] = '0;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            head[s] = POOL_ENTRIES;
        end
    endfunction

    function automatic void link_into(int s, int e);
        link[e] = POOL_ENTRIES;
        if (head[s] >= POOL_ENTRIES) begin
            head[s] = e;
        end else begin
            link[tail[s]] = e;
        end
        tail[s] = e;
    endfunction

    // Put an entry on the wheel by how far off its expiry is.
    function automatic void file_entry(int e);
        logic [31:0] rem;
        logic [63:0] exp64;
        rem   = due_tick[e] - now_tick;
        exp64 = {32'd0, due_tick[e]};
        if (rem < NEAR_SLOTS) begin
            link_into(int'(due_tick[e][NEAR_BITS-1:0]), e);
            return;
        end
        for (int i = 0; i < UPPER_LEVELS; i++) begin
            if (i == UPPER_LEVELS - 1 ||
                {32'd0, rem} < (64'd1 << (NEAR_BITS + (i + 1) * LEVEL_BITS))) begin
                link_into(NEAR_SLOTS + i * LEVEL_SLOTS +
                          int'((exp64 >> (NEAR_BITS + i * LEVEL_BITS)) & (LEVEL_SLOTS - 1)), e);
                return;
            end
        end
    endfunction

    // Detach an upper slot and spread its entries downward.
    function automatic void spread_slot(int level, int idx);
        int s;
        int e;
        int nx;
        s = NEAR_SLOTS + level * LEVEL_SLOTS + idx;
        e = head[s];
        head[s] = POOL_ENTRIES;
        for (int g = 0; g < POOL_ENTRIES && e < POOL_ENTRIES; g++) begin
            nx = link[e];
            file_entry(e);
            e = nx;
        end
    endfunction

    function automatic void emit_result(logic [2:0] kind, int id);
        rsp_t r;
        r.kind       = kind;
        r.expired_id = 6'(id);
        r.last       = 1'b0;
        batch_q.insert(batch_q.size(), r);
    endfunction

    // Fire the near slot for the current tick; recurring timers re-arm.
    function automatic void fire_current();
        int s;
        int e;
        int nx;
        s = int'(now_tick[NEAR_BITS-1:0]);
        e = head[s];
        head[s] = POOL_ENTRIES;
        for (int g = 0; g < POOL_ENTRIES && e < POOL_ENTRIES; g++) begin
            nx = link[e];
            if (flags[e] & FLAG_CANCEL) begin
                flags[e] = '0;
            end else begin
                emit_result(KIND_EXPIRED, e);
                if (flags[e] & FLAG_RECUR) begin
                    due_tick[e] = now_tick + {1'b0, period[e]};
                    file_entry(e);
                end else begin
                    flags[e] = '0;
                end
            end
            e = nx;
        end
    endfunction

    // Step the tick count and cascade the upper slot whose digit rolled over.
    function automatic void step_tick();
        logic [63:0] ct;
        logic [63:0] mask;
        logic [63:0] t;
        now_tick = now_tick + 32'd1;
        ct = {32'd0, now_tick};
        if (now_tick == 32'd0) begin
            spread_slot(UPPER_LEVELS - 1, 0);
            return;
        end
        mask = 64'(NEAR_SLOTS);
        t    = ct >> NEAR_BITS;
        for (int i = 0; i < UPPER_LEVELS; i++) begin
            if ((ct & (mask - 64'd1)) != 64'd0) begin
                return;
            end
            if ((t & (LEVEL_SLOTS - 1)) != 64'd0) begin
                spread_slot(i, int'(t & (LEVEL_SLOTS - 1)));
                return;
            end
            mask = mask << LEVEL_BITS;
            t    = t >> LEVEL_BITS;
        end
    endfunction

    // Work out every result item of one request.
    function automatic void predict_request(req_t rq);
        int id;
        id = int'(rq.timer_id);
        batch_q.delete();
        if (rq.func == FUNC_TICK) begin
            fire_current();
            step_tick();
            fire_current();
            if (batch_q.size() == 0) begin
                emit_result(KIND_NONE, 0);
            end
        end else if (rq.func == FUNC_ADD) begin
            if (id >= POOL_ENTRIES || (flags[id] & FLAG_LINKED)) begin
                emit_result(KIND_REJECTED, id);
            end else if (rq.interval_ticks == '0) begin
                emit_result(KIND_IMMEDIATE, id);
            end else begin
                period[id]   = rq.interval_ticks;
                due_tick[id] = now_tick + {1'b0, rq.interval_ticks};
                flags[id]    = FLAG_LINKED | (rq.recurring ? FLAG_RECUR : 3'b000);
                file_entry(id);
                emit_result(KIND_ADDED, id);
            end
        end else if (rq.func == FUNC_CANCEL) begin
            if (id < POOL_ENTRIES && (flags[id] & FLAG_LINKED) && !(flags[id] & FLAG_CANCEL)) begin
                flags[id] = flags[id] | FLAG_CANCEL;
                emit_result(KIND_CANCELLED, id);
            end else begin
                emit_result(KIND_REJECTED, id);
            end
        end else begin
            emit_result(KIND_REJECTED, id);
        end
        batch_q[batch_q.size() - 1].last = 1'b1;
        foreach (batch_q[k]) begin
            outcome_q.insert(outcome_q.size(), batch_q[k]);
        end
    endfunction

    // Results are compared before the request of the same edge is predicted.
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            error_count = 0;
            clear_wheel();
            outcome_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result item kind=%0d id=%0d", m_data.kind,
                           m_data.expired_id);
                    error_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_data.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_data.kind);
                        error_count++;
                    end
                    if (m_data.expired_id !== want.expired_id) begin
                        $error("expired_id: expected %0d, got %0d", want.expired_id,
                               m_data.expired_id);
                        error_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_data.last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_data);
            end
        end
    end

endmodule

### bench/hierarchical_timer_wheel_test.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_test
// Drives tick, add and cancel requests into the timer wheel with random gaps
// and output stalls, including one long stall that backs up the block, and
// reports the verdict from the checker's count of mismatches.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_test;
    import htw_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    int   error_count;
    int   pending;
    bit   stimulus_done = 1'b0;

    always #6 aclk = ~aclk;

    hierarchical_timer_wheel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hierarchical_timer_wheel_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .pending     (pending)
    );

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_request(logic [1:0] func, int id, logic [30:0] ivl, logic rec);
        int gap;
        req_t rq;
        gap = draw_gap();
        rq.func           = func;
        rq.timer_id       = 6'(id);
        rq.interval_ticks = ivl;
        rq.recurring      = rec;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stimulus: directed corner cases, then mostly ticks with random adds and cancels.
    initial begin
        logic [30:0] ivl;
        int pick;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        send_request(FUNC_ADD, 0, 31'd1, 1'b0);
        send_request(FUNC_TICK, 0, 31'd0, 1'b0);
        send_request(FUNC_ADD, 7, 31'd0, 1'b1);
        send_request(FUNC_ADD, 1, 31'h7FFF_FFFF, 1'b1);
        send_request(FUNC_ADD, 1, 31'd5, 1'b0);
        send_request(FUNC_CANCEL, 1, 31'd0, 1'b0);
        send_request(FUNC_CANCEL, 1, 31'd0, 1'b0);
        send_request(FUNC_ADD, 1, 31'd3, 1'b0);
        send_request(FUNC_CANCEL, 5, 31'd0, 1'b0);
        send_request(FUNC_UNKNOWN, 42, 31'h5555_5555, 1'b1);
        send_request(FUNC_ADD, 63, 31'd300, 1'b0);
        send_request(FUNC_ADD, 62, 31'd20000, 1'b1);
        send_request(FUNC_ADD, 2, 31'd1, 1'b1);
        send_request(FUNC_ADD, 3, 31'd2, 1'b0);
        send_request(FUNC_TICK, 0, 31'd0, 1'b0);
        send_request(FUNC_TICK, 0, 31'd0, 1'b0);
        send_request(FUNC_CANCEL, 2, 31'd0, 1'b0);
        send_request(FUNC_TICK, 0, 31'd0, 1'b0);
        send_request(FUNC_TICK, 0, 31'd0, 1'b0);
        for (int n = 0; n < 300; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       ivl = 31'($urandom());
                1:       ivl = 31'($urandom_range(0, 2));
                2, 3:    ivl = 31'($urandom_range(250, 5000));
                default: ivl = 31'($urandom_range(1, 300));
            endcase
            if (pick < 78) begin
                send_request(FUNC_TICK, $urandom_range(0, 63), 31'($urandom()), 1'($urandom()));
            end else if (pick < 92) begin
                send_request(FUNC_ADD, $urandom_range(0, 63), ivl, 1'($urandom_range(0, 3) == 0));
            end else if (pick < 98) begin
                send_request(FUNC_CANCEL, $urandom_range(0, 63), ivl, 1'($urandom()));
            end else begin
                send_request(FUNC_UNKNOWN, $urandom_range(0, 63), ivl, 1'($urandom()));
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result side: random stalls, and one long hold-off that backs up the block.
    initial begin
        int wait_cycles;
        int taken;
        taken = 0;
        repeat (12) @(posedge aclk);
        forever begin
            wait_cycles = (taken == 40) ? 600 : draw_gap();
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // Verdict once every expected item has come and the block has settled.
    initial begin
        wait (stimulus_done);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 2_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
